// ----- src/edtm_pkg.sv -----
// shared constants and field widths for the echo distance trimmed mean unit
// no dependencies; used by the channel interfaces and every module in src
package edtm_pkg;

   localparam int WINDOW_DEFAULT = 8;

   localparam int WIDTH_W   = 16;   // echo width in microseconds
   localparam int OFFSET_W  = 20;   // signed q.8 offset
   localparam int SAMPLE_W  = 21;   // signed q.8 sample and mean
   localparam int DIST_W    = 19;   // unsigned q.8 distance
   localparam int DPROD_W   = 28;   // width * 1114 + 128

   localparam logic [10:0] DIST_MUL = 11'd1114;   // 0.017 * 256 * 256
   localparam logic [7:0]  DIST_RND = 8'd128;
   localparam int          DIST_SHIFT = 8;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERT = 1'b1;

endpackage

// ----- src/edtm_if.sv -----
// valid/ready channel interfaces for the request and response sides
// depends on edtm_pkg for the payload widths
interface edtm_req_if;
   logic                            valid;
   logic                            ready;
   logic [edtm_pkg::WIDTH_W-1:0]    echo_width_us;

   modport source (output valid, output echo_width_us, input ready);
   modport sink   (input valid, input echo_width_us, output ready);
endinterface

interface edtm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [edtm_pkg::SAMPLE_W-1:0] mean_distance_q8;

   modport source (output valid, output mean_distance_q8, input ready);
   modport sink   (input valid, input mean_distance_q8, output ready);
endinterface

// ----- src/echo_distance_trimmed_mean_unit.sv -----
// echo distance trimmed mean: multiply, ring write, ring scan, trim, then divide to the result
// one request in flight; the next request is taken after the quotient of the last is done
// the ring scan does one memory read per cycle; the divide waits for a free result register
// the result register lets a new request in while the last result waits
// synchronous reset clears ring (valid bits), slot pointer and registers at once
module echo_distance_trimmed_mean_unit #(
   parameter int WINDOW = edtm_pkg::WINDOW_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   edtm_req_if.sink                             req_if,
   edtm_rsp_if.source                           rsp_if,
   input  logic                                 csr_we,
   input  logic [edtm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [edtm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam int SUM_W = edtm_pkg::SAMPLE_W + $clog2(WINDOW);
   localparam int EXT_W = SUM_W - edtm_pkg::SAMPLE_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

   // controller states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_WRITE = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_LAST  = 3'd4;
   localparam logic [2:0] S_TRIM  = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_WAIT  = 3'd7;

   logic [2:0] state_ff, state_in;

   // configuration
   logic signed [edtm_pkg::OFFSET_W-1:0] offset_ff;
   logic                                 invert_ff;

   // payload path
   logic [edtm_pkg::WIDTH_W-1:0]         width_ff;
   logic [edtm_pkg::DIST_W-1:0]          dist_ff;
   logic [edtm_pkg::DPROD_W-1:0]         dist_prod;
   logic signed [edtm_pkg::SAMPLE_W-1:0] sample;
   logic signed [edtm_pkg::SAMPLE_W-1:0] off_ext, dist_ext;

   // ring access
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             ring_wr, ring_rd;
   logic signed [edtm_pkg::SAMPLE_W-1:0] ring_data;
   logic             rd_pend_ff, rd_pend_in;

   // running statistics over the scan
   logic                                 first_ff, first_in;
   logic signed [SUM_W-1:0]              sum_ff, sum_in;
   logic signed [edtm_pkg::SAMPLE_W-1:0] hi_ff, hi_in, lo_ff, lo_in;
   logic signed [SUM_W-1:0]              trim_ff, trim_in;
   logic signed [SUM_W-1:0]              ring_ext;

   // divider and response register
   logic                                 div_start, div_done;
   logic signed [edtm_pkg::SAMPLE_W-1:0] div_q;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [edtm_pkg::SAMPLE_W-1:0] rsp_data_ff;
   logic                                 req_fire;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.mean_distance_q8 = rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         invert_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            edtm_pkg::REG_OFFSET: offset_ff <= $signed(csr_wdata);
            edtm_pkg::REG_INVERT: invert_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // width * 0.017 in q.8, rounded
   assign dist_prod = edtm_pkg::DPROD_W'(width_ff) * edtm_pkg::DPROD_W'(edtm_pkg::DIST_MUL)
                    + edtm_pkg::DPROD_W'(edtm_pkg::DIST_RND);

   assign off_ext  = {offset_ff[edtm_pkg::OFFSET_W-1], offset_ff};
   assign dist_ext = $signed({2'b00, dist_ff});
   assign sample   = invert_ff ? (off_ext - dist_ext) : (off_ext + dist_ext);

   assign ring_ext = {{EXT_W{ring_data[edtm_pkg::SAMPLE_W-1]}}, ring_data};

   always_ff @(posedge clock) begin
      if (req_fire) begin
         width_ff <= req_if.echo_width_us;
      end
      if (state_ff == S_MUL) begin
         dist_ff <= dist_prod[edtm_pkg::DIST_SHIFT + edtm_pkg::DIST_W - 1 : edtm_pkg::DIST_SHIFT];
      end
      if (div_done) begin
         rsp_data_ff <= div_q;
      end
      sum_ff  <= sum_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      trim_ff <= trim_in;
   end

   // controller
   always_comb begin
      state_in   = state_ff;
      slot_in    = slot_ff;
      idx_in     = idx_ff;
      first_in   = first_ff;
      ring_wr    = 1'b0;
      ring_rd    = 1'b0;
      rd_pend_in = 1'b0;
      div_start  = 1'b0;
      sum_in     = sum_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      trim_in    = trim_ff;

      // fold in the entry read last cycle
      if (rd_pend_ff) begin
         if (first_ff) begin
            sum_in   = ring_ext;
            hi_in    = ring_data;
            lo_in    = ring_data;
            first_in = 1'b0;
         end else begin
            sum_in = sum_ff + ring_ext;
            if (ring_data > hi_ff) begin
               hi_in = ring_data;
            end
            if (ring_data < lo_ff) begin
               lo_in = ring_data;
            end
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            // write the new sample, then rescan the whole ring
            ring_wr  = 1'b1;
            slot_in  = (slot_ff == LAST_IDX) ? '0 : slot_ff + 1'b1;
            idx_in   = '0;
            first_in = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            ring_rd    = 1'b1;
            rd_pend_in = 1'b1;
            idx_in     = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            state_in = S_TRIM;
         end
         S_TRIM: begin
            // drop one largest and one smallest
            trim_in  = sum_ff - {{EXT_W{hi_ff[edtm_pkg::SAMPLE_W-1]}}, hi_ff}
                              - {{EXT_W{lo_ff[edtm_pkg::SAMPLE_W-1]}}, lo_ff};
            state_in = S_DIV;
         end
         S_DIV: begin
            // start only when the response register will be free
            if (!rsp_valid_ff || rsp_if.ready) begin
               div_start = 1'b1;
               state_in  = S_WAIT;
            end
         end
         S_WAIT: begin
            if (div_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (div_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= '0;
         idx_ff       <= '0;
         first_ff     <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         idx_ff       <= idx_in;
         first_ff     <= first_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   edtm_ring #(
      .DEPTH  (WINDOW),
      .ADDR_W (IDX_W),
      .DATA_W (edtm_pkg::SAMPLE_W)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ring_wr),
      .wr_addr (slot_ff),
      .wr_data (sample),
      .rd_en   (ring_rd),
      .rd_addr (idx_ff),
      .rd_data (ring_data)
   );

   edtm_div #(
      .SUM_W   (SUM_W),
      .DIVISOR (WINDOW - 2)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (trim_ff),
      .done     (div_done),
      .quotient (div_q)
   );

`ifndef SYNTHESIS
   // a finished quotient never lands on an undelivered result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      div_done |-> !rsp_valid_ff)
      else $error("result register overwritten");

   // ring read data only shows up during the scan
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == S_SCAN || state_ff == S_LAST))
      else $error("ring read outside scan");

   // extremes are ordered once the scan is done
   a_hi_lo_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TRIM |-> hi_ff >= lo_ff)
      else $error("scan extremes out of order");

   // every request walks through the ring write after the multiply
   a_req_to_write: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> ##1 state_ff == S_WRITE)
      else $error("request did not reach ring write");
`endif

endmodule

// ----- src/edtm_ring.sv -----
// sample ring: single port write, single port read, registered read data
// per-entry valid bits cleared by reset, unwritten entries read as zero
module edtm_ring #(
   parameter int DEPTH  = edtm_pkg::WINDOW_DEFAULT,
   parameter int ADDR_W = $clog2(edtm_pkg::WINDOW_DEFAULT),
   parameter int DATA_W = edtm_pkg::SAMPLE_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

// ----- src/edtm_div.sv -----
// signed division by a constant, truncated toward zero
// reciprocal multiply; start is registered into v1 and then v2, which is done; depends on edtm_pkg
module edtm_div #(
   parameter int SUM_W   = edtm_pkg::SAMPLE_W + $clog2(edtm_pkg::WINDOW_DEFAULT),
   parameter int DIVISOR = edtm_pkg::WINDOW_DEFAULT - 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [SUM_W-1:0]              dividend,
   output logic                                 done,
   output logic signed [edtm_pkg::SAMPLE_W-1:0] quotient
);

   // magnitude stays below DIVISOR * 2^20
   localparam int L_W   = $clog2(DIVISOR);
   localparam int MAG_W = edtm_pkg::SAMPLE_W - 1 + L_W;
   localparam int SHIFT = MAG_W + L_W;
   localparam int MUL_W = MAG_W + 2;
   localparam int PROD_W = MAG_W + MUL_W;
   localparam logic [63:0] POW_K = 64'd1 << SHIFT;
   localparam logic [63:0] RECIP_64 = (POW_K + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [MUL_W-1:0] RECIP = RECIP_64[MUL_W-1:0];

   logic              v1_ff, v2_ff;
   logic              neg1_ff, neg2_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [SUM_W-1:0]  abs_val;
   logic [edtm_pkg::SAMPLE_W-1:0] q_mag;

   assign abs_val = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg1_ff <= dividend[SUM_W-1];
         mag_ff  <= abs_val[MAG_W-1:0];
      end
      if (v1_ff) begin
         neg2_ff <= neg1_ff;
         prod_ff <= PROD_W'(mag_ff) * PROD_W'(RECIP);
      end
   end

   assign q_mag    = {1'b0, prod_ff[SHIFT + edtm_pkg::SAMPLE_W - 2 : SHIFT]};
   assign quotient = neg2_ff ? -$signed(q_mag) : $signed(q_mag);
   assign done     = v2_ff;

endmodule

// ----- sim/echo_distance_trimmed_mean_unit_test.sv -----
// self-checking regression for the echo distance trimmed mean unit
// depends on src/edtm_pkg.sv, src/edtm_if.sv and src/echo_distance_trimmed_mean_unit.sv
module echo_distance_trimmed_mean_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_DEFAULT = edtm_pkg::WINDOW_DEFAULT;
   localparam int WIDTH_W        = edtm_pkg::WIDTH_W;
   localparam int OFFSET_W       = edtm_pkg::OFFSET_W;
   localparam int SAMPLE_W       = edtm_pkg::SAMPLE_W;
   localparam int DPROD_W        = edtm_pkg::DPROD_W;
   localparam int DIST_SHIFT     = edtm_pkg::DIST_SHIFT;
   localparam int CSR_INDEX_W    = edtm_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W     = edtm_pkg::CSR_DATA_W;
   localparam logic [10:0] DIST_MUL = edtm_pkg::DIST_MUL;
   localparam logic [7:0]  DIST_RND = edtm_pkg::DIST_RND;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET = edtm_pkg::REG_OFFSET;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERT = edtm_pkg::REG_INVERT;

   localparam int WINDOW      = WINDOW_DEFAULT;
   localparam int CYCLE_LIMIT = 300000;   // far beyond the slowest legal run
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 100;
   localparam int PRINT_CAP     = 50;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   edtm_req_if req_ch();
   edtm_rsp_if rsp_ch();

   echo_distance_trimmed_mean_unit #(.WINDOW(WINDOW)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // echo widths waiting to be offered, and trimmed means waiting to be seen
   logic [WIDTH_W-1:0]         echo_widths_pending[$];
   logic signed [SAMPLE_W-1:0] expected_means[$];

   // private copy of the block state and its register settings
   int                         ring_samples[WINDOW];
   int                         ring_slot;
   logic signed [OFFSET_W-1:0] offset_setting;
   logic                       invert_setting;

   bit steady_flow;     // when set neither side inserts idle cycles
   int hold_off;        // idle cycles left before the next request
   int stall_left;      // cycles left with the response side not ready
   int error_count;
   int accepted_count;
   int checked_count;
   int setting_count;
   int cycle_count;

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // width -> distance -> sample into the ring, then mean without one max and one min
   function automatic logic signed [SAMPLE_W-1:0] advance_ring_mean(
         logic [WIDTH_W-1:0] width);
      logic [DPROD_W-1:0] prod;
      int     dist_q8;
      int     smp;
      int     hi;
      int     lo;
      int     i;
      longint total;
      prod = DPROD_W'(width) * DPROD_W'(DIST_MUL) + DPROD_W'(DIST_RND);
      dist_q8 = int'(prod >> DIST_SHIFT);
      // the offset always fits, so the sample never needs saturation
      smp = invert_setting ? int'(offset_setting) - dist_q8 : int'(offset_setting) + dist_q8;
      ring_samples[ring_slot] = smp;
      ring_slot = (ring_slot + 1) % WINDOW;
      hi = ring_samples[0];
      lo = ring_samples[0];
      total = 0;
      for (i = 0; i < WINDOW; i++) begin
         total += ring_samples[i];
         if (ring_samples[i] > hi) hi = ring_samples[i];
         if (ring_samples[i] < lo) lo = ring_samples[i];
      end
      // ties drop only one instance each; division truncates toward zero
      total = total - hi - lo;
      return SAMPLE_W'(total / (WINDOW - 2));
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // one register write, applied to the private copy at the same moment
   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      if (index == REG_OFFSET) offset_setting = data[OFFSET_W-1:0];
      else if (index == REG_INVERT) invert_setting = data[0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // both registers; only bit 0 of the invert word matters
   task automatic apply_setting(logic [CSR_DATA_W-1:0] offset_word,
                                logic [CSR_DATA_W-1:0] invert_word);
      write_csr(REG_OFFSET, offset_word);
      write_csr(REG_INVERT, invert_word);
      setting_count++;
   endtask

   // idle means nothing queued, nothing offered and no result outstanding
   task automatic wait_for_drain();
      do @(negedge clock);
      while (echo_widths_pending.size() != 0 || req_ch.valid || expected_means.size() != 0);
   endtask

   task automatic queue_widths(logic [WIDTH_W-1:0] widths[$]);
      foreach (widths[k]) echo_widths_pending.push_back(widths[k]);
   endtask

   // mix of full range, short echoes, repeats for ties and the two extremes
   function automatic logic [WIDTH_W-1:0] pick_width(logic [WIDTH_W-1:0] prev);
      unique case ($urandom_range(0, 9))
         5:       return WIDTH_W'($urandom_range(0, 255));
         6:       return prev;
         7:       return '0;
         8:       return '1;
         9:       return WIDTH_W'($urandom_range(65000, 65535));
         default: return WIDTH_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_offset();
      unique case ($urandom_range(0, 5))
         0:       return 20'h80000;                      // most negative
         1:       return 20'h7FFFF;                      // most positive
         2:       return '0;
         3:       return CSR_DATA_W'($urandom_range(0, 4095) - 2048);
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   // request driver: holds each request until taken, then draws a gap
   always @(posedge clock) begin : drive_requests
      logic fire;
      int   wait_cycles;
      if (reset) begin
         req_ch.valid         <= 1'b0;
         req_ch.echo_width_us <= '0;
         hold_off             <= 0;
      end else begin
         fire        = req_ch.valid && req_ch.ready;
         wait_cycles = hold_off;
         if (fire) begin
            expected_means.push_back(advance_ring_mean(req_ch.echo_width_us));
            accepted_count++;
            wait_cycles = steady_flow ? 0 : $urandom_range(0, 3);
         end
         if (req_ch.valid && !fire) begin
            // request still waiting, keep it on the bus
         end else if (wait_cycles > 0) begin
            req_ch.valid <= 1'b0;
            hold_off     <= wait_cycles - 1;
         end else if (echo_widths_pending.size() != 0) begin
            req_ch.valid         <= 1'b1;
            req_ch.echo_width_us <= echo_widths_pending.pop_front();
            hold_off             <= 0;
         end else begin
            req_ch.valid <= 1'b0;
            hold_off     <= 0;
         end
      end
   end

   // response monitor: checks each result and draws a stall after it
   always @(posedge clock) begin : watch_results
      logic signed [SAMPLE_W-1:0] want;
      int                         stall;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else begin
         stall = stall_left;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_means.size() == 0) begin
               report_mismatch($sformatf("result %0d with no request outstanding",
                                         rsp_ch.mean_distance_q8));
            end else begin
               want = expected_means.pop_front();
               checked_count++;
               if (rsp_ch.mean_distance_q8 !== want)
                  report_mismatch($sformatf("mean_distance_q8 got %0d expected %0d",
                                            rsp_ch.mean_distance_q8, want));
            end
            stall = steady_flow ? 0 : $urandom_range(0, 3);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left   <= 0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("echo_distance_trimmed_mean_unit regression: fail");
         $finish;
      end
   end

   initial begin : run_regression
      logic [WIDTH_W-1:0] prev;
      int                 p;
      int                 n;
      // known values on every input from time zero
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.echo_width_us = '0;
      rsp_ch.ready         = 1'b0;
      steady_flow          = 1'b0;
      hold_off             = 0;
      stall_left           = 0;
      error_count          = 0;
      accepted_count       = 0;
      checked_count        = 0;
      setting_count        = 0;
      cycle_count          = 0;
      // private state mirrors reset: empty ring, slot zero, registers zero
      foreach (ring_samples[k]) ring_samples[k] = 0;
      ring_slot      = 0;
      offset_setting = '0;
      invert_setting = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero offset, add; invert word has its upper bits set but bit 0 clear
      apply_setting(20'h00000, 20'hFFFFE);
      // widest echoes among zero entries, then ties at zero
      queue_widths('{16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd1, 16'd0});
      wait_for_drain();

      // most negative offset, add
      apply_setting(20'h80000, 20'h00000);
      queue_widths('{16'd65535, 16'd0, 16'd0, 16'd65535, 16'd255, 16'd256});
      wait_for_drain();

      // most positive offset, subtract
      apply_setting(20'h7FFFF, 20'hFFFFF);
      queue_widths('{16'd0, 16'd65535, 16'd65535, 16'd32768, 16'd1, 16'd65535});
      wait_for_drain();

      // most negative offset minus the longest echo: deepest negative samples
      // and negative means that truncate toward zero
      apply_setting(20'h80000, 20'h00001);
      queue_widths('{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd12345});
      wait_for_drain();

      // random phases, each with its own setting; every third one without idling
      prev = '0;
      for (p = 0; p < RANDOM_PHASES; p++) begin
         steady_flow = (p % 3 == 2);
         apply_setting(pick_offset(), CSR_DATA_W'($urandom));
         for (n = 0; n < PHASE_ITEMS; n++) begin
            prev = pick_width(prev);
            echo_widths_pending.push_back(prev);
         end
         wait_for_drain();
      end

      // a further window of cycles to catch any stray result
      steady_flow = 1'b0;
      repeat (WINDOW + 8) @(negedge clock);
      if (expected_means.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_means.size()));

      $display("%0d requests over %0d register settings, %0d means checked",
               accepted_count, setting_count, checked_count);
      $display("%0d mismatches", error_count);
      if (error_count == 0)
         $display("echo_distance_trimmed_mean_unit regression: pass");
      else
         $display("echo_distance_trimmed_mean_unit regression: fail");
      $finish;
   end

endmodule
